FILE: hdl/lzbd_pkg.sv
// Shared types and constants for the LZ block decompressor.
package lzbd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned CNT_W    = 25;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP_LEN = 1'd1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLEAN_END = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LIT_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_OFF   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd6;

  localparam logic [LEN_W-1:0]  MIN_LENGTH  = 24'd17;
  localparam logic [LEN_W-1:0]  XOR_SPAN    = 24'd16;
  localparam logic [3:0]        NIBBLE_EXT  = 4'hF;
  localparam logic [BYTE_W-1:0] CHAIN_BYTE  = 8'hFF;
  localparam logic [CNT_W-1:0]  MIN_MATCH   = 25'd4;
  localparam logic [CNT_W-1:0]  MATCH_EXT   = 25'd19;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                has_byte;
    logic [STATUS_W-1:0] status;
    logic                match_pending;
  } out_t;

  // Per-transaction decode outcome handed from the control unit to the datapath
  typedef struct packed {
    out_t result;   // out_byte carries the literal, or zero
    logic is_pull;  // out_byte comes from the history ring
    logic rd_en;
    logic wr_en;
  } step_t;

endpackage

FILE: hdl/lzbd_ring.sv
// History ring: one write port, one read port with registered read data.
module lzbd_ring import lzbd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/lzbd_ctrl.sv
// Decode control: configuration, stream parser, counters and ring addressing.
module lzbd_ctrl import lzbd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  input  logic                 accept,
  input  in_t                  item,
  output step_t                step,
  output logic [AW-1:0]        rd_addr,
  output logic [AW-1:0]        wr_addr
);

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITEXT, PH_LITERALS, PH_OFFLO,
    PH_OFFHI, PH_MATCHEXT, PH_MATCH, PH_DONE
  } phase_t;

  localparam logic [AW:0] WC_MAX = (AW+1)'(HISTORY_DEPTH);

  logic [BYTE_W-1:0]   xor_key;
  logic [LEN_W-1:0]    comp_length;
  logic [AW-1:0]       wp, wp_next;
  logic [AW:0]         written_count, written_count_next;
  logic [LEN_W-1:0]    in_pos, in_pos_next;
  phase_t              phase, phase_next;
  logic [CNT_W-1:0]    lit_rem, lit_rem_next;
  logic [CNT_W-1:0]    match_rem, match_rem_next;
  logic [OFF_W-1:0]    match_off, match_off_next;
  logic [STATUS_W-1:0] final_status, final_status_next;

  logic                too_short, at_end, fin, store;
  logic [STATUS_W-1:0] fin_code, st;
  logic [BYTE_W-1:0]   bx;
  logic [LEN_W-1:0]    in_pos_inc;
  logic [CNT_W:0]      lit_sum, match_sum;
  logic [OFF_W-1:0]    off_full;
  logic [CNT_W-1:0]    lit_dec;

  always_comb begin
    too_short  = comp_length < MIN_LENGTH;
    bx         = (in_pos < XOR_SPAN) ? (item.in_byte ^ xor_key) : item.in_byte;
    in_pos_inc = in_pos + 1'b1;
    at_end     = in_pos_inc >= comp_length;
    lit_sum    = {1'b0, lit_rem} + (CNT_W+1)'(bx);
    match_sum  = {1'b0, match_rem} + (CNT_W+1)'(bx);
    off_full   = {bx, match_off[7:0]};
    lit_dec    = lit_rem - 1'b1;

    wp_next            = wp;
    written_count_next = written_count;
    in_pos_next        = in_pos;
    phase_next         = phase;
    lit_rem_next       = lit_rem;
    match_rem_next     = match_rem;
    match_off_next     = match_off;
    final_status_next  = final_status;
    fin      = 1'b0;
    fin_code = ST_RUNNING;
    st       = ST_RUNNING;
    store    = 1'b0;
    step     = '0;

    if (too_short) begin
      st = ST_TOO_SHORT;
    end else if (phase == PH_DONE) begin
      st = final_status;
    end else if (item.action) begin
      if (phase == PH_MATCH) begin
        store               = 1'b1;
        step.is_pull        = 1'b1;
        step.rd_en          = 1'b1;
        step.result.has_byte = 1'b1;
        match_rem_next      = match_rem - 1'b1;
        if (match_rem == CNT_W'(1)) begin
          if (in_pos >= comp_length) begin
            fin      = 1'b1;
            fin_code = ST_CLEAN_END;
          end else begin
            phase_next = PH_TOKEN;
          end
        end
      end
    end else if (phase == PH_MATCH) begin
      st = ST_BUSY;
    end else begin
      in_pos_next = in_pos_inc;
      case (phase)
        PH_TOKEN: begin
          match_rem_next = CNT_W'(bx[3:0]) + MIN_MATCH;
          lit_rem_next   = CNT_W'(bx[7:4]);
          if (bx[7:4] == NIBBLE_EXT) begin
            phase_next = PH_LITEXT;
          end else if (bx[7:4] == 4'd0) begin
            phase_next = PH_OFFLO;
          end else begin
            phase_next = PH_LITERALS;
          end
          if (at_end) begin
            fin      = 1'b1;
            fin_code = (bx[7:4] == 4'd0) ? ST_CLEAN_END : ST_LIT_OVER;
          end
        end
        PH_LITEXT: begin
          lit_rem_next = lit_sum[CNT_W] ? '1 : lit_sum[CNT_W-1:0];
          if (bx != CHAIN_BYTE) begin
            phase_next = PH_LITERALS;
          end
          if (at_end) begin
            fin      = 1'b1;
            fin_code = ST_LIT_OVER;
          end
        end
        PH_LITERALS: begin
          store                = 1'b1;
          step.result.has_byte = 1'b1;
          step.result.out_byte = bx;
          lit_rem_next         = lit_dec;
          if (at_end) begin
            fin      = 1'b1;
            fin_code = (lit_dec == '0) ? ST_CLEAN_END : ST_LIT_OVER;
          end else if (lit_dec == '0) begin
            phase_next = PH_OFFLO;
          end
        end
        PH_OFFLO: begin
          match_off_next = OFF_W'(bx);
          phase_next     = PH_OFFHI;
          if (at_end) begin
            fin      = 1'b1;
            fin_code = ST_TRUNCATED;
          end
        end
        PH_OFFHI: begin
          match_off_next = off_full;
          if (off_full == '0 || (AW+1)'(off_full) > written_count) begin
            fin      = 1'b1;
            fin_code = ST_BAD_OFF;
          end else if (match_rem == MATCH_EXT) begin
            phase_next = PH_MATCHEXT;
            if (at_end) begin
              fin      = 1'b1;
              fin_code = ST_TRUNCATED;
            end
          end else begin
            phase_next = PH_MATCH;
          end
        end
        PH_MATCHEXT: begin
          match_rem_next = match_sum[CNT_W] ? '1 : match_sum[CNT_W-1:0];
          if (bx != CHAIN_BYTE) begin
            phase_next = PH_MATCH;
          end else if (at_end) begin
            fin      = 1'b1;
            fin_code = ST_TRUNCATED;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end

    if (store) begin
      step.wr_en = 1'b1;
      wp_next    = wp + 1'b1;
      if (written_count < WC_MAX) begin
        written_count_next = written_count + 1'b1;
      end
    end
    if (fin) begin
      phase_next        = PH_DONE;
      final_status_next = fin_code;
      st                = fin_code;
    end
    step.result.status        = st;
    step.result.match_pending = !too_short && (phase_next == PH_MATCH);
    rd_addr = wp - match_off[AW-1:0];
    wr_addr = wp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key       <= '0;
      comp_length   <= '0;
      wp            <= '0;
      written_count <= '0;
      in_pos        <= '0;
      phase         <= PH_TOKEN;
      lit_rem       <= '0;
      match_rem     <= '0;
      match_off     <= '0;
      final_status  <= ST_RUNNING;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_XOR_KEY:  xor_key     <= cfg_data[BYTE_W-1:0];
          CFG_COMP_LEN: comp_length <= cfg_data;
          default:      xor_key     <= xor_key;
        endcase
      end
      if (accept) begin
        wp            <= wp_next;
        written_count <= written_count_next;
        in_pos        <= in_pos_next;
        phase         <= phase_next;
        lit_rem       <= lit_rem_next;
        match_rem     <= match_rem_next;
        match_off     <= match_off_next;
        final_status  <= final_status_next;
      end
    end
  end

endmodule

FILE: hdl/lz_block_decompressor.sv
// Top level of the LZ block decompressor: control, history ring and result pipeline.
// Stage 1 and then the output register lie between an accepted transaction and its result.
// Throughput: one transaction per cycle, literal or match pull alike, while out_stall
//   is low; the single ring read and write ports are each used at most once per transaction.
// Reset: rst clears all control state and both registers; the ring needs no clearing
//   pass, as no offset may reach an entry that was never written.
module lz_block_decompressor import lzbd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic              accept, advance;
  step_t             step;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [BYTE_W-1:0] rd_data;

  // Stage 1: waits for the ring read; performs the ring write as it leaves
  logic              s1_valid;
  step_t             s1_step;
  logic [AW-1:0]     s1_waddr;
  logic              s1_fwd;
  logic [BYTE_W-1:0] s1_fwd_data;
  logic [BYTE_W-1:0] s1_byte;
  logic              ring_we;

  // Advance when the output register is empty or being drained this cycle
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  lzbd_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_data),
    .step      (step),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  // The byte that stage 1 delivers and stores: a literal from the stream, or the
  // ring copy. A write landing on the same entry in the cycle of the read is not
  // yet visible in the ring, so take the forwarded byte instead.
  always_comb begin
    if (s1_step.is_pull) begin
      s1_byte = s1_fwd ? s1_fwd_data : rd_data;
    end else begin
      s1_byte = s1_step.result.out_byte;
    end
  end

  // Write each stored byte once, as its transaction leaves stage 1
  assign ring_we = s1_valid && s1_step.wr_en && advance;

  lzbd_ring #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (s1_waddr),
    .wr_data (s1_byte),
    .rd_en   (accept && step.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid  <= accept;
        out_valid <= s1_valid;
      end else if (accept) begin
        // Stage 1 was empty behind a held output: fill it
        s1_valid  <= 1'b1;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step     <= step;
      s1_waddr    <= wr_addr;
      s1_fwd      <= ring_we && step.rd_en && (s1_waddr == rd_addr);
      s1_fwd_data <= s1_byte;
    end
    if (advance && s1_valid) begin
      out_data.out_byte      <= s1_byte;
      out_data.has_byte      <= s1_step.result.has_byte;
      out_data.status        <= s1_step.result.status;
      out_data.match_pending <= s1_step.result.match_pending;
    end
  end

`ifndef ASSERT_OFF
  // The input side only holds back when stage 1 is occupied and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked pipeline");

  // Forwarding applies to ring copies only
  a_fwd_pull: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_fwd) |-> s1_step.is_pull)
    else $error("forwarded byte on a non-pull transaction");

  // A result without a byte carries a zero byte
  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.has_byte) |-> (out_data.out_byte == '0))
    else $error("out_byte set while has_byte is low");

  // Every accepted transaction occupies stage 1 in the next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction lost before stage 1");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for the LZ block decompressor: stream stimulus, prediction, result check.
`timescale 1ns / 1ps

module tb;
  import lzbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Transaction kinds on the input channel
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LIT_EXT, PH_LITERALS, PH_OFF_LO, PH_OFF_HI, PH_MATCH_EXT, PH_MATCH, PH_DONE
  } phase_t;

  typedef enum int {
    END_AFTER_LITERALS, END_AFTER_TOKEN, END_AFTER_MATCH,
    END_LIT_OVERRUN, END_BAD_OFFSET, END_TRUNCATED
  } ending_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;

  lz_block_decompressor u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Decoder state as the block should hold it
  logic [BYTE_W-1:0]   hist [0:65535];
  logic [15:0]         wr_ptr;
  logic [16:0]         n_written;
  logic [LEN_W-1:0]    in_pos;
  phase_t              phase;
  logic [CNT_W-1:0]    lit_left;
  logic [CNT_W-1:0]    match_left;
  logic [OFF_W-1:0]    match_off;
  logic [STATUS_W-1:0] end_status;
  logic [BYTE_W-1:0]   key_reg;
  logic [LEN_W-1:0]    len_reg;

  in_t  feed_q[$];        // transactions waiting to be offered
  out_t expected_out[$];  // predicted results, oldest first

  // Stream builder's view of the decoder, resynchronised at every register write
  logic [LEN_W-1:0]  gen_pos;
  int unsigned       gen_written;
  logic [BYTE_W-1:0] gen_key;

  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 55;
  bit          hold_request = 1'b0;
  int unsigned hold_cycles = 0;
  bit          in_taken = 1'b0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [BYTE_W-1:0] v);
    logic [CNT_W:0] s;
    s = a + v;
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  function automatic void keep_byte(input logic [BYTE_W-1:0] v);
    hist[wr_ptr] = v;
    wr_ptr = wr_ptr + 1'b1;
    if (n_written < 17'h10000) n_written = n_written + 1'b1;
  endfunction

  function automatic logic [STATUS_W-1:0] end_block(input logic [STATUS_W-1:0] code);
    phase = PH_DONE;
    end_status = code;
    return code;
  endfunction

  // Advance the predicted decoder by one transaction and return its result
  function automatic out_t decode_step(input in_t item);
    out_t              res;
    logic [BYTE_W-1:0] b;
    logic [15:0]       src;
    logic              at_end;
    res = '0;
    b = item.in_byte;
    if (len_reg < MIN_LENGTH) begin
      res.status = ST_TOO_SHORT;
    end else if (phase == PH_DONE) begin
      res.status = end_status;
    end else if (item.action == ACT_PULL) begin
      // a pull with nothing pending just reports running
      if (phase == PH_MATCH) begin
        src = wr_ptr - match_off;
        res.out_byte = hist[src];
        res.has_byte = 1'b1;
        keep_byte(res.out_byte);
        match_left = match_left - 1'b1;
        if (match_left == '0) begin
          if (in_pos >= len_reg) res.status = end_block(ST_CLEAN_END);
          else phase = PH_TOKEN;
        end
      end
    end else if (phase == PH_MATCH) begin
      res.status = ST_BUSY;
    end else begin
      if (in_pos < XOR_SPAN) b = b ^ key_reg;
      in_pos = in_pos + 1'b1;
      at_end = (in_pos >= len_reg);
      case (phase)
        PH_TOKEN: begin
          lit_left = CNT_W'(b[7:4]);
          match_left = CNT_W'(b[3:0]) + MIN_MATCH;
          if (b[7:4] == NIBBLE_EXT) phase = PH_LIT_EXT;
          else if (b[7:4] == 4'd0) phase = PH_OFF_LO;
          else phase = PH_LITERALS;
          if (at_end) res.status = end_block(b[7:4] == 4'd0 ? ST_CLEAN_END : ST_LIT_OVER);
        end
        PH_LIT_EXT: begin
          lit_left = sat_add(lit_left, b);
          if (b != CHAIN_BYTE) phase = PH_LITERALS;
          if (at_end) res.status = end_block(ST_LIT_OVER);
        end
        PH_LITERALS: begin
          keep_byte(b);
          res.out_byte = b;
          res.has_byte = 1'b1;
          lit_left = lit_left - 1'b1;
          if (at_end) res.status = end_block(lit_left == '0 ? ST_CLEAN_END : ST_LIT_OVER);
          else if (lit_left == '0) phase = PH_OFF_LO;
        end
        PH_OFF_LO: begin
          match_off = {8'h00, b};
          phase = PH_OFF_HI;
          if (at_end) res.status = end_block(ST_TRUNCATED);
        end
        PH_OFF_HI: begin
          match_off[15:8] = b;
          if (match_off == '0 || 17'(match_off) > n_written) begin
            res.status = end_block(ST_BAD_OFF);
          end else if (match_left == MATCH_EXT) begin
            phase = PH_MATCH_EXT;
            if (at_end) res.status = end_block(ST_TRUNCATED);
          end else begin
            phase = PH_MATCH;
          end
        end
        default: begin
          // match length extension; a clean stop here is reported by the last pull
          match_left = sat_add(match_left, b);
          if (b != CHAIN_BYTE) phase = PH_MATCH;
          else if (at_end) res.status = end_block(ST_TRUNCATED);
        end
      endcase
    end
    res.match_pending = (len_reg >= MIN_LENGTH) && (phase == PH_MATCH);
    return res;
  endfunction

  // Predict on every accepted input transaction and check every accepted result
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      wr_ptr = '0;
      n_written = '0;
      in_pos = '0;
      phase = PH_TOKEN;
      lit_left = '0;
      match_left = '0;
      match_off = '0;
      end_status = ST_RUNNING;
      key_reg = '0;
      len_reg = '0;
      in_taken = 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_XOR_KEY:  key_reg = cfg_data[BYTE_W-1:0];
          CFG_COMP_LEN: len_reg = cfg_data;
          default: ;
        endcase
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) expected_out.push_back(decode_step(in_data));
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got byte %h has %b status %0d pending %b",
                   $time, out_data.out_byte, out_data.has_byte, out_data.status,
                   out_data.match_pending);
        end else begin
          want = expected_out.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.has_byte !== want.has_byte ||
              out_data.status !== want.status ||
              out_data.match_pending !== want.match_pending) begin
            fail_count++;
            $display("%0t: mismatch, expected byte %h has %b status %0d pending %b",
                     $time, want.out_byte, want.has_byte, want.status, want.match_pending);
            $display("%0t:           got byte %h has %b status %0d pending %b",
                     $time, out_data.out_byte, out_data.has_byte, out_data.status,
                     out_data.match_pending);
          end
        end
      end
    end
  end

  // Sender: hold a stalled transaction, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= feed_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_request && hold_cycles < LONG_HOLD) begin
      hold_cycles++;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic push_raw(input logic act, input logic [BYTE_W-1:0] v);
    in_t item;
    item.action = act;
    item.in_byte = v;
    feed_q.push_back(item);
  endtask

  // Queue one compressed byte, pre-scrambled where the block will unscramble it
  task automatic push_byte(input logic [BYTE_W-1:0] v);
    push_raw(ACT_BYTE, gen_pos < XOR_SPAN ? v ^ gen_key : v);
    gen_pos = gen_pos + 1'b1;
  endtask

  task automatic push_chain(input int e);
    while (e >= 255) begin
      push_byte(CHAIN_BYTE);
      e -= 255;
    end
    push_byte(8'(e));
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_raw($urandom_range(1) ? ACT_PULL : ACT_BYTE, 8'($urandom));
  endtask

  function automatic int ext_bytes(input int count, input int base);
    return count >= base ? (count - base) / 255 + 1 : 0;
  endfunction

  // One well-formed sequence: token, literal extension, literals, offset, match extension,
  // then the pulls, with the odd refused byte slipped in while the match is pending
  task automatic push_sequence(input int lits, input int mlen, input logic [15:0] off);
    logic [3:0] lnib, mnib;
    lnib = lits >= 15 ? NIBBLE_EXT : 4'(lits);
    mnib = mlen >= 19 ? NIBBLE_EXT : 4'(mlen - 4);
    push_byte({lnib, mnib});
    if (lnib == NIBBLE_EXT) push_chain(lits - 15);
    repeat (lits) push_byte(8'($urandom));
    push_byte(off[7:0]);
    push_byte(off[15:8]);
    if (mnib == NIBBLE_EXT) push_chain(mlen - 19);
    repeat (mlen) begin
      if ($urandom_range(9) == 0) push_raw(ACT_BYTE, 8'($urandom));
      push_raw(ACT_PULL, 8'($urandom));
    end
    gen_written = gen_written + lits + mlen;
    if (gen_written > 65536) gen_written = 65536;
  endtask

  task automatic push_random_part(input int n_items);
    int lits, mlen, pick, reach;
    logic [15:0] off;
    while (feed_q.size() < n_items) begin
      if ($urandom_range(9) == 0) push_raw(ACT_PULL, 8'($urandom));
      pick = $urandom_range(99);
      if (pick < 70) lits = $urandom_range(0, 14);
      else if (pick < 95) lits = $urandom_range(15, 60);
      else lits = $urandom_range(270, 320);
      pick = $urandom_range(99);
      if (pick < 75) mlen = $urandom_range(4, 18);
      else if (pick < 95) mlen = $urandom_range(19, 60);
      else mlen = $urandom_range(274, 320);
      if (gen_written + lits == 0) lits = 1;
      reach = gen_written + lits;
      if (reach > 65535) reach = 65535;
      if ($urandom_range(99) < 80) off = 16'($urandom_range(1, reach < 32 ? reach : 32));
      else off = 16'($urandom_range(1, reach));
      push_sequence(lits, mlen, off);
    end
  endtask

  // Wait until every queued transaction has gone in and its result come back
  task automatic settle();
    while (feed_q.size() != 0 || expected_out.size() != 0 || in_valid) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    gen_key = key_reg;
    gen_pos = in_pos;
    gen_written = n_written;
  endtask

  initial begin
    int          lits, mlen, cut, reach;
    logic [15:0] off;
    ending_t     kind;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers at reset: length zero, so every transaction reports too short
    push_raw(ACT_BYTE, 8'h00);
    push_raw(ACT_BYTE, 8'hFF);
    push_raw(ACT_PULL, 8'hFF);
    settle();

    // One below the minimum length is still too short
    write_reg(CFG_XOR_KEY, LEN_W'(8'hFF));
    write_reg(CFG_COMP_LEN, LEN_W'(16));
    push_raw(ACT_BYTE, 8'h5A);
    push_raw(ACT_PULL, 8'h00);
    settle();

    // Longest block, full key: the scrambled header bytes all have every bit flipped
    write_reg(CFG_COMP_LEN, LEN_MAX);
    push_raw(ACT_PULL, 8'hFF);       // pull with nothing pending
    push_byte(8'h20);                // two literals, shortest match
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h02);                // offset two, overlapping copy
    push_byte(8'h00);
    push_raw(ACT_BYTE, 8'h00);       // refused while the match is pending
    repeat (4) push_raw(ACT_PULL, 8'h00);
    push_raw(ACT_PULL, 8'h00);
    gen_written = gen_written + 6;
    push_random_part(650);
    settle();

    send_idle_pct = 55;
    recv_idle_pct = 18;
    push_random_part(650);
    settle();

    // Drop below the minimum length mid-block: nothing moves until it is restored
    write_reg(CFG_COMP_LEN, LEN_W'(5));
    write_reg(CFG_XOR_KEY, LEN_W'($urandom_range(255)));
    push_noise(20);
    settle();
    write_reg(CFG_COMP_LEN, LEN_MAX);

    // No idling, and one long receiver hold-off so the block backs up to its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    push_random_part(700);
    settle();

    // Close the block one way or another, then check the final status is held
    write_reg(CFG_XOR_KEY, LEN_W'($urandom_range(255)));
    kind = ending_t'($urandom_range(0, 5));
    lits = $urandom_range(1, 40);
    mlen = $urandom_range(4, 30);
    cut = 0;
    case (kind)
      END_AFTER_TOKEN:    begin lits = 0; cut = 1; end
      END_AFTER_LITERALS: cut = 1 + ext_bytes(lits, 15) + lits;
      END_AFTER_MATCH:    cut = 1 + ext_bytes(lits, 15) + lits + 2 + ext_bytes(mlen, 19);
      END_LIT_OVERRUN:    cut = $urandom_range(1, ext_bytes(lits, 15) + lits);
      END_TRUNCATED: begin
        // stop on the low offset byte, the high one, or a chained extension byte
        mlen = $urandom_range(274, 300);
        cut = 1 + ext_bytes(lits, 15) + lits + $urandom_range(1, 3);
      end
      default: ;
    endcase
    reach = gen_written + lits;
    if (reach > 65535) reach = 65535;
    if (kind == END_BAD_OFFSET)
      off = ($urandom_range(1) == 0 || reach >= 65535) ? 16'h0 : 16'(reach + 1);
    else off = 16'($urandom_range(1, reach < 1 ? 1 : reach));
    write_reg(CFG_COMP_LEN, kind == END_BAD_OFFSET ? LEN_MAX : gen_pos + LEN_W'(cut));
    push_sequence(lits, mlen, off);
    push_noise(10);
    settle();
    repeat (8) @(negedge clk);

    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
